FILE: design/g2e_pkg.sv
package g2e_pkg;

    // field widths
    localparam int ANG_W     = 32;
    localparam int H_W       = 28;
    localparam int OUT_W     = 34;
    localparam int AXIS_W    = 33;
    localparam int ECC_W     = 32;
    localparam int CFG_W     = 33;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AXIS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ECC  = 1'b1;

    localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
    localparam logic [ECC_W-1:0]  ECC_RESET  = 32'd28752143;

    // cordic
    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES > 40) ? 40 : CORDIC_STAGES;
    localparam int TRIG_W        = 44;
    localparam int Z_W           = 34;
    localparam logic signed [TRIG_W-1:0] CORDIC_K = 44'sd667681663043;

    // arithmetic units
    localparam int MUL_W      = 52;
    localparam int HALF_W     = MUL_W / 2;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MUL_LAT    = 4;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 50;
    localparam int DVD_W      = AXIS_W + 31 + 1;
    localparam int QUO_W      = DIV_STEPS;

    // positions along the post-cordic pipe
    localparam int P_T      = 0;
    localparam int P_SQ     = P_T + MUL_LAT + 1;
    localparam int P_D      = P_SQ + MUL_LAT + 1;
    localparam int P_ROOT   = P_D + SQRT_STEPS;
    localparam int P_DVD    = P_ROOT + 1;
    localparam int P_N      = P_DVD + DIV_STEPS + 1;
    localparam int P_PR     = P_N + MUL_LAT + 1;
    localparam int P_H      = P_PR + 1;
    localparam int P_F      = P_H + MUL_LAT + 1;
    localparam int PIPE_LEN = P_F + 1;

    localparam logic [63:0] OUT_LIM = 64'd1 << (OUT_W - 1);

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [Z_W-1:0]    z;
    } cordic_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] work;
    } sqrt_t;

    typedef struct packed {
        logic [31:0]      rem;
        logic [31:0]      dvsr;
        logic [QUO_W-1:0] work;
    } div_t;

    typedef struct packed {
        logic                  flip_lat;
        logic                  flip_lon;
        logic signed [H_W-1:0] h;
    } side_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] slat;
        logic signed [TRIG_W-1:0] clat;
        logic signed [TRIG_W-1:0] slon;
        logic signed [TRIG_W-1:0] clon;
        logic signed [H_W-1:0]    h;
    } trig_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } result_t;

    // atan(2^-i) in units of pi/2^31
    function automatic logic [29:0] atan_units(input logic [5:0] i);
        case (i)
            6'd0:  atan_units = 30'd536870912;
            6'd1:  atan_units = 30'd316933406;
            6'd2:  atan_units = 30'd167458907;
            6'd3:  atan_units = 30'd85004756;
            6'd4:  atan_units = 30'd42667331;
            6'd5:  atan_units = 30'd21354465;
            6'd6:  atan_units = 30'd10680350;
            6'd7:  atan_units = 30'd5340245;
            6'd8:  atan_units = 30'd2670163;
            6'd9:  atan_units = 30'd1335087;
            6'd10: atan_units = 30'd667544;
            6'd11: atan_units = 30'd333772;
            6'd12: atan_units = 30'd166886;
            6'd13: atan_units = 30'd83443;
            6'd14: atan_units = 30'd41722;
            6'd15: atan_units = 30'd20861;
            6'd16: atan_units = 30'd10430;
            6'd17: atan_units = 30'd5215;
            6'd18: atan_units = 30'd2608;
            6'd19: atan_units = 30'd1304;
            6'd20: atan_units = 30'd652;
            6'd21: atan_units = 30'd326;
            6'd22: atan_units = 30'd163;
            6'd23: atan_units = 30'd81;
            6'd24: atan_units = 30'd41;
            6'd25: atan_units = 30'd20;
            6'd26: atan_units = 30'd10;
            6'd27: atan_units = 30'd5;
            6'd28: atan_units = 30'd3;
            6'd29: atan_units = 30'd1;
            6'd30: atan_units = 30'd1;
            default: atan_units = 30'd0;
        endcase
    endfunction

    // magnitude product divided by 2^s, rounded half up
    function automatic logic [63:0] round_shr(input logic [PROD_W-1:0] p, input int s);
        logic [PROD_W:0] t;
        t = {1'b0, p} + ((PROD_W + 1)'(1) << (s - 1));
        round_shr = 64'(t >> s);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic [63:0] mag,
                                                         input logic neg);
        logic [63:0] neg_val;
        neg_val = -mag;
        if (neg)
            sat_out = (mag > OUT_LIM) ? {1'b1, {(OUT_W-1){1'b0}}}
                                      : signed'(neg_val[OUT_W-1:0]);
        else
            sat_out = (mag > OUT_LIM - 64'd1) ? {1'b0, {(OUT_W-1){1'b1}}}
                                              : signed'(mag[OUT_W-1:0]);
    endfunction

endpackage

FILE: design/g2e_if.sv
interface g2e_geo_if;
    import g2e_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] latitude;
    logic signed [ANG_W-1:0] longitude;
    logic signed [H_W-1:0]   height_mm;

    modport source (output valid, latitude, longitude, height_mm, input ready);
    modport sink (input valid, latitude, longitude, height_mm, output ready);
endinterface

interface g2e_ecef_if;
    import g2e_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] ecef_x;
    logic signed [OUT_W-1:0] ecef_y;
    logic signed [OUT_W-1:0] ecef_z;

    modport source (output valid, ecef_x, ecef_y, ecef_z, input ready);
    modport sink (input valid, ecef_x, ecef_y, ecef_z, output ready);
endinterface

FILE: design/g2e_cordic_cell.sv
module g2e_cordic_cell (
    input  logic             clk,
    input  logic             en,
    input  logic [5:0]       shift,
    input  g2e_pkg::cordic_t c_in,
    output g2e_pkg::cordic_t c_out
);
    import g2e_pkg::*;

    cordic_t                  state_reg;
    cordic_t                  state_next;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [Z_W-1:0]    at;

    always_comb
    begin
        dx = c_in.y >>> shift;
        dy = c_in.x >>> shift;
        at = signed'(Z_W'(atan_units(shift)));
        if (!c_in.z[Z_W-1])
        begin
            state_next.x = c_in.x - dx;
            state_next.y = c_in.y + dy;
            state_next.z = c_in.z - at;
        end
        else
        begin
            state_next.x = c_in.x + dx;
            state_next.y = c_in.y - dy;
            state_next.z = c_in.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            state_reg <= state_next;
    end

    assign c_out = state_reg;

endmodule

FILE: design/g2e_sqrt_cell.sv
module g2e_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  g2e_pkg::sqrt_t s_in,
    output g2e_pkg::sqrt_t s_out
);
    import g2e_pkg::*;

    sqrt_t       state_reg;
    sqrt_t       state_next;
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;

    // two radicand bits in, one root bit out
    always_comb
    begin
        r2    = {s_in.rem, s_in.work[63:62]};
        trial = {2'b00, s_in.root, 2'b01};
        ge    = (r2 >= trial);
        state_next.rem  = ge ? 34'(r2 - trial) : r2[33:0];
        state_next.root = {s_in.root[30:0], ge};
        state_next.work = {s_in.work[61:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            state_reg <= state_next;
    end

    assign s_out = state_reg;

endmodule

FILE: design/g2e_div_cell.sv
module g2e_div_cell (
    input  logic          clk,
    input  logic          en,
    input  g2e_pkg::div_t d_in,
    output g2e_pkg::div_t d_out
);
    import g2e_pkg::*;

    div_t        state_reg;
    div_t        state_next;
    logic [32:0] r2;
    logic        ge;

    // dividend bits shift out at the top, quotient bits in at the bottom
    always_comb
    begin
        r2 = {d_in.rem, d_in.work[QUO_W-1]};
        ge = (r2 >= {1'b0, d_in.dvsr});
        state_next.rem  = ge ? 32'(r2 - {1'b0, d_in.dvsr}) : r2[31:0];
        state_next.dvsr = d_in.dvsr;
        state_next.work = {d_in.work[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            state_reg <= state_next;
    end

    assign d_out = state_reg;

endmodule

FILE: design/g2e_mul.sv
module g2e_mul (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [g2e_pkg::MUL_W-1:0]   a,
    input  logic signed [g2e_pkg::MUL_W-1:0]   b,
    output logic        [g2e_pkg::PROD_W-1:0]  prod,
    output logic                               neg
);
    import g2e_pkg::*;

    logic [MUL_W-1:0]  ma_reg;
    logic [MUL_W-1:0]  mb_reg;
    logic [MUL_W-1:0]  pp00_reg;
    logic [MUL_W-1:0]  pp01_reg;
    logic [MUL_W-1:0]  pp10_reg;
    logic [MUL_W-1:0]  pp11_reg;
    logic [MUL_W:0]    mid_reg;
    logic [PROD_W-1:0] outer_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [3:0]        neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes and sign
            ma_reg     <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
            mb_reg     <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
            neg_reg[0] <= a[MUL_W-1] ^ b[MUL_W-1];
            // half-width partial products
            pp00_reg   <= ma_reg[HALF_W-1:0] * mb_reg[HALF_W-1:0];
            pp01_reg   <= ma_reg[HALF_W-1:0] * mb_reg[MUL_W-1:HALF_W];
            pp10_reg   <= ma_reg[MUL_W-1:HALF_W] * mb_reg[HALF_W-1:0];
            pp11_reg   <= ma_reg[MUL_W-1:HALF_W] * mb_reg[MUL_W-1:HALF_W];
            neg_reg[1] <= neg_reg[0];
            mid_reg    <= {1'b0, pp01_reg} + {1'b0, pp10_reg};
            outer_reg  <= {pp11_reg, pp00_reg};
            neg_reg[2] <= neg_reg[1];
            prod_reg   <= outer_reg + (PROD_W'(mid_reg) << HALF_W);
            neg_reg[3] <= neg_reg[2];
        end
    end

    assign prod = prod_reg;
    assign neg  = neg_reg[3];

endmodule

FILE: design/geodetic_to_ecef.sv
// geodetic to earth-centred earth-fixed conversion
//
// geo channel: latitude and longitude as signed fractions of pi, height in mm.
// ecef channel: x, y and z in mm, saturated to 34 bits signed.
// cfg port: cfg_we with cfg_index 0 (semi-major axis, mm) or 1 (eccentricity
// squared, q0.32); write only while no item is in flight.
//
// one item is taken every cycle while geo.ready is high. on its way to ecef,
// each item passes a chain of CORDIC_N rotation cells, four-stage split
// multipliers, a 32-cell square-root chain and a 50-cell divider chain for
// the prime-vertical radius.
//
// reset loads wgs84 into both registers and empties the pipe and the
// two-entry result buffer. when ecef stalls, the pipe runs until the
// buffer is full; then it holds and geo.ready drops. nothing is lost.
module geodetic_to_ecef (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [g2e_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [g2e_pkg::CFG_W-1:0]       cfg_data,
    g2e_geo_if.sink                         geo,
    g2e_ecef_if.source                      ecef
);
    import g2e_pkg::*;

    logic [AXIS_W-1:0] axis_reg;
    logic [ECC_W-1:0]  ecc_reg;
    logic              en;

    // cordic section
    cordic_t lat_d [CORDIC_N];
    cordic_t lat_c [CORDIC_N];
    cordic_t lon_d [CORDIC_N];
    cordic_t lon_c [CORDIC_N];
    side_t   side_reg [CORDIC_N];
    logic    cv_reg [CORDIC_N];
    logic    flip_lat;
    logic    flip_lon;
    trig_t   trig_next;

    // post-cordic pipe
    trig_t   trig_reg [P_H+1];
    logic    vld_reg [PIPE_LEN];

    logic [PROD_W-1:0] p_sq, p_t, p_a, p_b, p_x, p_y, p_z;
    logic              neg_a, neg_x, neg_y, neg_z;
    logic [63:0]       sq_full;

    logic [32:0]              sq_reg;
    logic [32:0]              d_reg;
    sqrt_t                    sq_d [SQRT_STEPS];
    sqrt_t                    sq_c [SQRT_STEPS];
    logic [DVD_W-1:0]         dvd_reg;
    logic [31:0]              dvsr_reg;
    div_t                     dv_d [DIV_STEPS];
    div_t                     dv_c [DIV_STEPS];
    logic signed [MUL_W-1:0]  nh_reg;
    logic [QUO_W-1:0]         n_reg;
    logic [63:0]              tmag_reg;
    logic                     tneg_reg;
    logic [63:0]              nb_reg;
    logic signed [MUL_W-1:0]  tmp_reg;
    logic signed [MUL_W-1:0]  nbh_reg;
    logic [63:0]              mx_reg, my_reg, mz_reg;
    logic                     nx_reg, ny_reg, nz_reg;

    // result buffer
    result_t   res_reg [2];
    result_t   res_next;
    logic      wr_ptr_reg;
    logic      rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic      push;
    logic      pop;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AXIS_RESET;
            ecc_reg  <= ECC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AXIS: axis_reg <= cfg_data[AXIS_W-1:0];
                REG_ECC:  ecc_reg  <= cfg_data[ECC_W-1:0];
                default:  ;
            endcase
        end
    end

    assign pop  = (count_reg != 2'd0) && ecef.ready;
    assign en   = (count_reg != 2'd2) || ecef.ready;
    assign push = vld_reg[P_F] && en;
    assign geo.ready = en;

    // fold into the right half plane, sin and cos are negated at the end
    assign flip_lat = geo.latitude[ANG_W-1] ^ geo.latitude[ANG_W-2];
    assign flip_lon = geo.longitude[ANG_W-1] ^ geo.longitude[ANG_W-2];

    always_comb
    begin
        lat_d[0].x = CORDIC_K;
        lat_d[0].y = '0;
        lat_d[0].z = signed'(Z_W'(signed'({geo.latitude[ANG_W-1] ^ flip_lat,
                                             geo.latitude[ANG_W-2:0]})));
        lon_d[0].x = CORDIC_K;
        lon_d[0].y = '0;
        lon_d[0].z = signed'(Z_W'(signed'({geo.longitude[ANG_W-1] ^ flip_lon,
                                             geo.longitude[ANG_W-2:0]})));
    end

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_cordic
        if (i > 0)
        begin : g_link
            assign lat_d[i] = lat_c[i-1];
            assign lon_d[i] = lon_c[i-1];
        end
        g2e_cordic_cell u_lat (
            .clk   (clk),
            .en    (en),
            .shift (6'(i)),
            .c_in  (lat_d[i]),
            .c_out (lat_c[i])
        );
        g2e_cordic_cell u_lon (
            .clk   (clk),
            .en    (en),
            .shift (6'(i)),
            .c_in  (lon_d[i]),
            .c_out (lon_c[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{flip_lat: flip_lat, flip_lon: flip_lon, h: geo.height_mm};
            for (int i = 1; i < CORDIC_N; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORDIC_N; i++)
                cv_reg[i] <= 1'b0;
            for (int p = 0; p < PIPE_LEN; p++)
                vld_reg[p] <= 1'b0;
        end
        else if (en)
        begin
            cv_reg[0] <= geo.valid;
            for (int i = 1; i < CORDIC_N; i++)
                cv_reg[i] <= cv_reg[i-1];
            vld_reg[0] <= cv_reg[CORDIC_N-1];
            for (int p = 1; p < PIPE_LEN; p++)
                vld_reg[p] <= vld_reg[p-1];
        end
    end

    always_comb
    begin
        trig_next.slat = side_reg[CORDIC_N-1].flip_lat ? -lat_c[CORDIC_N-1].y
                                                        : lat_c[CORDIC_N-1].y;
        trig_next.clat = side_reg[CORDIC_N-1].flip_lat ? -lat_c[CORDIC_N-1].x
                                                        : lat_c[CORDIC_N-1].x;
        trig_next.slon = side_reg[CORDIC_N-1].flip_lon ? -lon_c[CORDIC_N-1].y
                                                        : lon_c[CORDIC_N-1].y;
        trig_next.clon = side_reg[CORDIC_N-1].flip_lon ? -lon_c[CORDIC_N-1].x
                                                        : lon_c[CORDIC_N-1].x;
        trig_next.h    = side_reg[CORDIC_N-1].h;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg[0] <= trig_next;
            for (int p = 1; p <= P_H; p++)
                trig_reg[p] <= trig_reg[p-1];
        end
    end

    // sin^2(lat)
    g2e_mul u_mul_sq (
        .clk  (clk),
        .en   (en),
        .a    (MUL_W'(trig_reg[P_T].slat)),
        .b    (MUL_W'(trig_reg[P_T].slat)),
        .prod (p_sq),
        .neg  ()
    );

    assign sq_full = round_shr(p_sq, 48);

    // e2 * sin^2
    g2e_mul u_mul_t (
        .clk  (clk),
        .en   (en),
        .a    (signed'(MUL_W'(ecc_reg))),
        .b    (signed'(MUL_W'(sq_reg))),
        .prod (p_t),
        .neg  ()
    );

    assign sq_d[0] = '{rem: '0, root: '0, work: {1'b0, d_reg, 30'b0}};

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        if (k > 0)
        begin : g_link
            assign sq_d[k] = sq_c[k-1];
        end
        g2e_sqrt_cell u_cell (
            .clk   (clk),
            .en    (en),
            .s_in  (sq_d[k]),
            .s_out (sq_c[k])
        );
    end

    // the divisor is at least 2^15, so the top dividend bits start the remainder
    assign dv_d[0] = '{rem:  32'(dvd_reg[DVD_W-1:QUO_W]),
                       dvsr: dvsr_reg,
                       work: dvd_reg[QUO_W-1:0]};

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        if (k > 0)
        begin : g_link
            assign dv_d[k] = dv_c[k-1];
        end
        g2e_div_cell u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (dv_d[k]),
            .d_out (dv_c[k])
        );
    end

    // (n + h) * cos(lat) and n * (1 - e2)
    g2e_mul u_mul_a (
        .clk  (clk),
        .en   (en),
        .a    (nh_reg),
        .b    (MUL_W'(trig_reg[P_N].clat)),
        .prod (p_a),
        .neg  (neg_a)
    );

    g2e_mul u_mul_b (
        .clk  (clk),
        .en   (en),
        .a    (signed'(MUL_W'(n_reg))),
        .b    (signed'(MUL_W'(33'h1_0000_0000 - {1'b0, ecc_reg}))),
        .prod (p_b),
        .neg  ()
    );

    g2e_mul u_mul_x (
        .clk  (clk),
        .en   (en),
        .a    (tmp_reg),
        .b    (MUL_W'(trig_reg[P_H].clon)),
        .prod (p_x),
        .neg  (neg_x)
    );

    g2e_mul u_mul_y (
        .clk  (clk),
        .en   (en),
        .a    (tmp_reg),
        .b    (MUL_W'(trig_reg[P_H].slon)),
        .prod (p_y),
        .neg  (neg_y)
    );

    g2e_mul u_mul_z (
        .clk  (clk),
        .en   (en),
        .a    (nbh_reg),
        .b    (MUL_W'(trig_reg[P_H].slat)),
        .prod (p_z),
        .neg  (neg_z)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= (sq_full > 64'h1_0000_0000) ? 33'h1_0000_0000 : sq_full[32:0];
            d_reg    <= 33'h1_0000_0000 - {1'b0, p_t[63:32]};
            dvd_reg  <= {1'b0, axis_reg, 31'b0} + DVD_W'(sq_c[SQRT_STEPS-1].root[31:1]);
            dvsr_reg <= sq_c[SQRT_STEPS-1].root;
            n_reg    <= dv_c[DIV_STEPS-1].work;
            nh_reg   <= signed'(MUL_W'(dv_c[DIV_STEPS-1].work))
                        + MUL_W'(trig_reg[P_N-1].h);
            tmag_reg <= round_shr(p_a, 40);
            tneg_reg <= neg_a;
            nb_reg   <= round_shr(p_b, 32);
            tmp_reg  <= tneg_reg ? -signed'(MUL_W'(tmag_reg)) : signed'(MUL_W'(tmag_reg));
            nbh_reg  <= signed'(MUL_W'(nb_reg)) + MUL_W'(trig_reg[P_PR].h);
            mx_reg   <= round_shr(p_x, 40);
            my_reg   <= round_shr(p_y, 40);
            mz_reg   <= round_shr(p_z, 40);
            nx_reg   <= neg_x;
            ny_reg   <= neg_y;
            nz_reg   <= neg_z;
        end
    end

    // result buffer, two entries
    always_comb
    begin
        res_next.x = sat_out(mx_reg, nx_reg);
        res_next.y = sat_out(my_reg, ny_reg);
        res_next.z = sat_out(mz_reg, nz_reg);
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            res_reg[wr_ptr_reg] <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign ecef.valid  = (count_reg != 2'd0);
    assign ecef.ecef_x = res_reg[rd_ptr_reg].x;
    assign ecef.ecef_y = res_reg[rd_ptr_reg].y;
    assign ecef.ecef_z = res_reg[rd_ptr_reg].z;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("result buffer count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && count_reg == 2'd2) |-> pop)
        else $error("transfer into a full result buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_D] |-> d_reg != 33'd0)
        else $error("radicand reached zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_ROOT] |-> sq_c[SQRT_STEPS-1].root[31:15] != 17'd0)
        else $error("square root below divider range");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import g2e_pkg::*;

    localparam int      N_STAGES  = 24;
    localparam int      LIMIT     = 400000;
    localparam longint  ROT_GAIN  = 64'sd667681663043;
    localparam longint unsigned MAG_CAP = 64'd1 << 62;
    localparam longint  ATAN_TAB [40] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680350, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    class ecef_scoreboard;
        result_t coords_due[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        function longint unsigned mul_round(input longint unsigned a,
                                            input longint unsigned b, input int s);
            logic [128:0] p;
            p = 129'(a) * 129'(b);
            p = p + (129'(1) << (s - 1));
            p = p >> s;
            if (p > 129'(MAG_CAP))
                return MAG_CAP;
            return p[63:0];
        endfunction

        function longint smul_round(input longint a, input longint b, input int s);
            longint unsigned ma;
            longint unsigned mb;
            longint m;
            ma = (a < 0) ? 64'd0 - longint'(a) : a;
            mb = (b < 0) ? 64'd0 - longint'(b) : b;
            m = longint'(mul_round(ma, mb, s));
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function longint unsigned int_sqrt(input longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // rotation cordic, angle in units of pi/2^31, results q40
        function void sin_cos(input logic [31:0] ang, output longint sn, output longint cs);
            logic [31:0] u;
            logic        flip;
            longint      x;
            longint      y;
            longint      z;
            longint      dx;
            longint      dy;
            u = ang;
            flip = u[31] ^ u[30];
            if (flip)
                u[31] = ~u[31];
            z = longint'(signed'(u));
            x = ROT_GAIN;
            y = 0;
            for (int i = 0; i < N_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
                end
                else
                begin
                    x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
                end
            end
            sn = flip ? -y : y;
            cs = flip ? -x : x;
        endfunction

        function logic signed [OUT_W-1:0] clip34(input longint v);
            if (v > (64'sd1 <<< 33) - 1)
                v = (64'sd1 <<< 33) - 1;
            if (v < -(64'sd1 <<< 33))
                v = -(64'sd1 <<< 33);
            return v[OUT_W-1:0];
        endfunction

        function void note_point(input logic [31:0] lat, input logic [31:0] lon,
                                 input logic signed [H_W-1:0] hgt,
                                 input longint unsigned axis, input longint unsigned ecc);
            longint          slat, clat, slon, clon, h, tmp;
            longint unsigned sq, t, d, r, n, nb;
            result_t         res;
            sin_cos(lat, slat, clat);
            sin_cos(lon, slon, clon);
            h = longint'(hgt);
            sq = longint'(smul_round(slat, slat, 48));
            if (sq > (64'd1 << 32))
                sq = 64'd1 << 32;
            t = (ecc * sq) >> 32;
            d = (64'd1 << 32) - t;
            r = int_sqrt(d << 30);
            n = ((axis << 31) + (r >> 1)) / r;
            tmp = smul_round(longint'(n) + h, clat, 40);
            res.x = clip34(smul_round(tmp, clon, 40));
            res.y = clip34(smul_round(tmp, slon, 40));
            nb = mul_round(n, (64'd1 << 32) - ecc, 32);
            res.z = clip34(smul_round(longint'(nb) + h, slat, 40));
            coords_due.push_back(res);
        endfunction

        task check_point(input result_t got);
            result_t want;
            if (coords_due.size() == 0)
            begin
                report($sformatf("unexpected transfer x=%0d y=%0d z=%0d",
                                 got.x, got.y, got.z));
                return;
            end
            want = coords_due.pop_front();
            if (got.x !== want.x)
                report($sformatf("ecef_x got %0d want %0d", got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("ecef_y got %0d want %0d", got.y, want.y));
            if (got.z !== want.z)
                report($sformatf("ecef_z got %0d want %0d", got.z, want.z));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    g2e_geo_if  geo ();
    g2e_ecef_if ecef ();

    geodetic_to_ecef uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geo       (geo.sink),
        .ecef      (ecef.source)
    );

    ecef_scoreboard  sb;
    longint unsigned axis_now;
    longint unsigned ecc_now;
    bit              quiet;
    int              cycles;
    int              stall_left;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("geodetic_to_ecef regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && geo.valid && geo.ready)
            sb.note_point(geo.latitude, geo.longitude, geo.height_mm, axis_now, ecc_now);
        if (rst_n && ecef.valid && ecef.ready)
            sb.check_point('{ecef.ecef_x, ecef.ecef_y, ecef.ecef_z});
    end

    // receiver stalls in short bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            ecef.ready = 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            ecef.ready = 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            ecef.ready = 1'b1;
    end

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[CFG_W-1:0];
        if (idx == REG_AXIS)
            axis_now = val & ((64'd1 << 33) - 1);
        else
            ecc_now = val & 64'hFFFF_FFFF;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // called at a falling edge right after the last transfer
    task drain;
        geo.valid = 1'b0;
        while (sb.coords_due.size() != 0)
            @(negedge clk);
    endtask

    // valid stays high from one transfer into the next unless a gap is drawn
    task send_point(input logic [31:0] lat, input logic [31:0] lon,
                    input logic [H_W-1:0] hgt);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            geo.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        geo.valid = 1'b1;
        geo.latitude = lat;
        geo.longitude = lon;
        geo.height_mm = hgt;
        do
            @(posedge clk);
        while (!geo.ready);
        @(negedge clk);
    endtask

    task send_random(input int count);
        logic [H_W-1:0] hgt;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                hgt = H_W'($urandom());
            else
                hgt = H_W'($urandom_range(0, 101000000) - 1000000);
            send_point($urandom(), $urandom(), hgt);
        end
    endtask

    initial
    begin
        logic [31:0] angs [10];
        sb = new();
        cycles = 0;
        stall_left = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_AXIS;
        cfg_data = '0;
        geo.valid = 1'b0;
        geo.latitude = '0;
        geo.longitude = '0;
        geo.height_mm = '0;
        ecef.ready = 1'b0;
        axis_now = 64'd6378137000;
        ecc_now = 64'd28752143;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // quadrant edges, poles and the wrap at pi
        angs = '{32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h3FFF_FFFF, 32'hBFFF_FFFF, 32'h2000_0000,
                 32'hE000_0000, 32'h0000_0001};
        for (int k = 0; k < 10; k++)
            send_point(angs[k], angs[9 - k], (k % 2) ? H_W'(-1000000) : H_W'(100000000));
        send_point(32'h4000_0000, 32'h0, {1'b0, {(H_W-1){1'b1}}});
        send_point(32'hC000_0000, 32'h8000_0000, {1'b1, {(H_W-1){1'b0}}});
        send_point(32'h1234_5678, 32'h8765_4321, '1);
        send_random(300);
        drain();
        send_random(20);
        drain();
        // large axis with a sphere drives the outputs into saturation
        write_reg(REG_AXIS, (64'd1 << 33) - 1);
        write_reg(REG_ECC, 0);
        send_point(32'h0, 32'h0, H_W'(100000000));
        send_point(32'h4000_0000, 32'h0, H_W'(100000000));
        send_random(150);
        drain();
        // zero axis and eccentricity at its top
        write_reg(REG_AXIS, 0);
        write_reg(REG_ECC, 64'hFFFF_FFFF);
        send_point(32'h4000_0000, 32'h2000_0000, H_W'(100000000));
        send_random(100);
        drain();
        write_reg(REG_AXIS, 1);
        write_reg(REG_ECC, 64'hFFFF_FFFF);
        send_point(32'h4000_0000, 32'h0, H_W'(0));
        send_random(80);
        drain();
        write_reg(REG_AXIS, {$urandom_range(0, 1), $urandom()});
        write_reg(REG_ECC, $urandom());
        send_random(150);
        drain();
        write_reg(REG_AXIS, 64'd6378137000);
        write_reg(REG_ECC, 64'd28752143);
        quiet = 1'b1;
        send_random(250);
        drain();
        repeat (CORDIC_N + 120) @(posedge clk);
        if (sb.errors == 0)
            $display("geodetic_to_ecef regression: pass");
        else
            $display("geodetic_to_ecef regression: fail");
        $finish;
    end
endmodule
